// File: rtl/core/ipc_pkg.sv
package ipc_pkg;

  // Operator stack geometry
  localparam int STACK_DEPTH = 32;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int SP_W        = $clog2(STACK_DEPTH + 1);

  // Most results one input item may produce; later ones are dropped
  localparam int MAX_RESULTS = 32;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

  // Characters with a meaning of their own
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;

  typedef enum logic [1:0] {
    KIND_CHAR = 2'd0,
    KIND_END  = 2'd1,
    KIND_ERR  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_OVERFLOW  = 2'd1,
    ERR_INVALID   = 2'd2,
    ERR_UNMATCHED = 2'd3
  } err_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_READ,
    ST_EVAL,
    ST_END,
    ST_DRAIN
  } state_e;

  // What the current pop loop is working for
  typedef enum logic [1:0] {
    MODE_OP,
    MODE_CLOSE,
    MODE_FLUSH
  } mode_e;

  typedef struct packed {
    logic [7:0] symbol;
    logic       end_of_expr;
  } in_t;

  typedef struct packed {
    logic [7:0] out_symbol;
    kind_e      kind;
    err_e       error_code;
    logic       last_of_run;
  } out_t;

  // Sequencer to stack memory
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } stk_req_t;

  // Sequencer to result buffer
  typedef struct packed {
    logic push;
    logic close;
    out_t res;
  } emit_req_t;

  function automatic logic [1:0] prec_f(logic [7:0] c);
    logic [1:0] p;
    case (c)
      CH_CARET:          p = 2'd3;
      CH_STAR, CH_SLASH: p = 2'd2;
      CH_PLUS, CH_MINUS: p = 2'd1;
      default:           p = 2'd0;
    endcase
    return p;
  endfunction

  function automatic logic is_alnum_f(logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h61 && c <= 8'h7A);
  endfunction

endpackage

// File: rtl/core/ipc_stack.sv
module ipc_stack
  import ipc_pkg::*;
(
  input  logic       clk_i,
  input  stk_req_t   req_i,
  output logic [7:0] rd_data_o
);

  logic [7:0] mem [STACK_DEPTH];
  logic [7:0] rd_data_q;

  // Write one entry
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  // Registered read, held between reads
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rd_data_q <= mem[req_i.raddr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: rtl/core/ipc_emit.sv
module ipc_emit
  import ipc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  emit_req_t req_i,
  output logic      ready_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_t      out_data_o
);

  logic pend_valid_q, pend_valid_d;
  out_t pend_q, pend_d;
  logic out_valid_q, out_valid_d;
  out_t out_q, out_d;
  logic out_free;
  logic load;

  // Output register frees when empty or when its transfer completes
  assign out_free = !out_valid_q || !out_stall_i;
  assign ready_o  = !pend_valid_q || out_free;
  assign load     = pend_valid_q && ready_o && (req_i.push || req_i.close);

  // Hold one result back until it is known whether it ends the run
  always_comb begin
    pend_valid_d = pend_valid_q;
    pend_d       = pend_q;
    out_d        = out_q;
    if (load) begin
      out_d             = pend_q;
      out_d.last_of_run = req_i.close;
    end
    if (req_i.push && ready_o) begin
      pend_valid_d       = 1'b1;
      pend_d             = req_i.res;
      pend_d.last_of_run = 1'b0;
    end else if (req_i.close && ready_o) begin
      pend_valid_d = 1'b0;
    end
    out_valid_d = load ? 1'b1 : (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_close_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.close && !req_i.push && ready_o) |=> !pend_valid_q)
    else $error("held result survived a close");

  a_push_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.push && ready_o) |=> pend_valid_q)
    else $error("pushed result not held");

  a_last_only_on_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && !req_i.close) |=> !out_q.last_of_run)
    else $error("run end flagged without a close");
`endif

endmodule

// File: rtl/core/ipc_seq.sv
module ipc_seq
  import ipc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  in_t        in_data_i,
  output stk_req_t   stk_o,
  input  logic [7:0] stk_rdata_i,
  output emit_req_t  emit_o,
  input  logic       emit_ready_i
);

  state_e          state_q, state_d;
  mode_e           mode_q, mode_d;
  logic [7:0]      sym_q, sym_d;
  logic            last_q, last_d;
  logic [1:0]      minprec_q, minprec_d;
  logic [SP_W-1:0] sp_q, sp_d;
  logic            skip_q, skip_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  logic       accept;
  logic       is_open, is_close, is_alnum;
  logic [1:0] sym_prec;
  logic       full, above_base, pop_cond;
  logic       want;
  out_t       res;
  logic       push, hold, fail_now;
  logic       proc_done, to_flush;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  // Classify the symbol and the stack top
  always_comb begin
    is_open    = (sym_q == CH_LPAREN);
    is_close   = (sym_q == CH_RPAREN);
    is_alnum   = is_alnum_f(sym_q);
    sym_prec   = prec_f(sym_q);
    full       = (sp_q >= SP_W'(STACK_DEPTH));
    above_base = (sp_q > SP_W'(1));
    pop_cond   = above_base && (stk_rdata_i != CH_LPAREN) &&
                 (prec_f(stk_rdata_i) >= minprec_q);
  end

  // Decide which result, if any, arises this cycle
  always_comb begin
    want           = 1'b0;
    res.out_symbol = 8'h00;
    res.kind       = KIND_CHAR;
    res.error_code = ERR_NONE;
    res.last_of_run = 1'b0;
    proc_done      = 1'b0;
    unique case (state_q)
      ST_DECODE: begin
        if (!skip_q) begin
          if (is_open) begin
            proc_done = 1'b1;
            if (full) begin
              want           = 1'b1;
              res.kind       = KIND_ERR;
              res.error_code = ERR_OVERFLOW;
            end
          end else if (is_alnum) begin
            proc_done      = 1'b1;
            want           = 1'b1;
            res.out_symbol = sym_q;
          end else if (sym_prec == 2'd0 && !is_close) begin
            proc_done      = 1'b1;
            want           = 1'b1;
            res.kind       = KIND_ERR;
            res.error_code = ERR_INVALID;
          end
        end
      end
      ST_EVAL: begin
        if (pop_cond) begin
          want           = 1'b1;
          res.out_symbol = stk_rdata_i;
        end else if (mode_q == MODE_OP) begin
          proc_done = 1'b1;
          if (full) begin
            want           = 1'b1;
            res.kind       = KIND_ERR;
            res.error_code = ERR_OVERFLOW;
          end
        end else if (mode_q == MODE_CLOSE) begin
          proc_done = 1'b1;
          if (!above_base) begin
            want           = 1'b1;
            res.kind       = KIND_ERR;
            res.error_code = ERR_UNMATCHED;
          end
        end
      end
      ST_END: begin
        want     = 1'b1;
        res.kind = KIND_END;
      end
      default: begin
        want = 1'b0;
      end
    endcase
    fail_now = want && (res.kind == KIND_ERR);
    push     = want && (cnt_q < CNT_W'(MAX_RESULTS));
    hold     = (push || state_q == ST_DRAIN) && !emit_ready_i;
    to_flush = proc_done && last_q && !fail_now;
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_DECODE;
      end
      ST_DECODE: begin
        if (!hold) begin
          if (skip_q) begin
            state_d = last_q ? ST_END : ST_DRAIN;
          end else if (!proc_done) begin
            state_d = ST_READ;
          end else if (to_flush) begin
            state_d = ST_READ;
          end else begin
            state_d = last_q ? ST_END : ST_DRAIN;
          end
        end
      end
      ST_READ: begin
        state_d = ST_EVAL;
      end
      ST_EVAL: begin
        if (!hold) begin
          if (pop_cond || to_flush) begin
            state_d = ST_READ;
          end else if (mode_q == MODE_FLUSH || last_q) begin
            state_d = ST_END;
          end else begin
            state_d = ST_DRAIN;
          end
        end
      end
      ST_END: begin
        if (!hold) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!hold) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath updates, stack and result requests
  always_comb begin
    mode_d    = mode_q;
    sym_d     = sym_q;
    last_d    = last_q;
    minprec_d = minprec_q;
    sp_d      = sp_q;
    skip_d    = skip_q;
    cnt_d     = cnt_q;
    stk_o.we    = 1'b0;
    stk_o.waddr = sp_q[ADDR_W-1:0];
    stk_o.wdata = sym_q;
    stk_o.re    = 1'b0;
    stk_o.raddr = ADDR_W'(sp_q - SP_W'(1));
    emit_o.push  = push;
    emit_o.close = (state_q == ST_DRAIN);
    emit_o.res   = res;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          sym_d  = in_data_i.symbol;
          last_d = in_data_i.end_of_expr;
          cnt_d  = '0;
        end
      end
      ST_DECODE: begin
        if (!hold && !skip_q) begin
          if (is_open && !full) begin
            stk_o.we = 1'b1;
            sp_d     = sp_q + SP_W'(1);
          end
          if (!proc_done) begin
            minprec_d = sym_prec;
            mode_d    = is_close ? MODE_CLOSE : MODE_OP;
          end
        end
      end
      ST_READ: begin
        stk_o.re = 1'b1;
      end
      ST_EVAL: begin
        if (!hold) begin
          if (pop_cond) begin
            sp_d = sp_q - SP_W'(1);
          end else if (mode_q == MODE_OP && !full) begin
            stk_o.we = 1'b1;
            sp_d     = sp_q + SP_W'(1);
          end else if (mode_q == MODE_CLOSE && above_base) begin
            sp_d = sp_q - SP_W'(1);
          end
        end
      end
      ST_END: begin
        if (!hold) begin
          sp_d   = SP_W'(1);
          skip_d = 1'b0;
        end
      end
      default: begin
        sp_d = sp_q;
      end
    endcase
    if (!hold && push) cnt_d = cnt_q + CNT_W'(1);
    if (!hold && fail_now) skip_d = 1'b1;
    // Switch the pop loop over to the final flush
    if (!hold && to_flush) begin
      mode_d    = MODE_FLUSH;
      minprec_d = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      mode_q    <= MODE_OP;
      minprec_q <= 2'd0;
      sp_q      <= SP_W'(1);
      skip_q    <= 1'b0;
      cnt_q     <= '0;
      last_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      mode_q    <= mode_d;
      minprec_q <= minprec_d;
      sp_q      <= sp_d;
      skip_q    <= skip_d;
      cnt_q     <= cnt_d;
      last_q    <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sym_q <= sym_d;
  end

`ifndef SYNTHESIS
  a_sp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sp_q >= SP_W'(1)) && (sp_q <= SP_W'(STACK_DEPTH)))
    else $error("stack pointer out of range");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_RESULTS))
    else $error("result count past limit");

  a_end_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_END && !hold) |=> (sp_q == SP_W'(1) && !skip_q))
    else $error("stack not reset after end of expression");

  a_flush_no_skip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EVAL && mode_q == MODE_FLUSH) |-> !skip_q)
    else $error("flush after an error");
`endif

endmodule

// File: rtl/core/infix_to_postfix_converter.sv
// Infix to postfix converter, one expression character per input transfer.
// Input channel: in_valid_i / in_stall_o with in_data_i (symbol and an
// end_of_expr flag on the last character). Output channel: out_valid_o /
// out_stall_i with out_data_o (postfix character, end marker or error;
// last_of_run marks the final result of one input character).
// An input character is decoded, then each operator stack entry it examines
// costs one registered memory read and one compare; an end character adds
// the flush of the remaining operators and the end marker. in_stall_o is
// high until the character is fully handled.
// Each result is held one step in a buffer so that the last one can be
// flagged, and leaves through an output register.
// A stalled receiver holds the output register; the sequencer then waits
// whenever a new result needs that register, and resumes when it frees.
// On reset the stack holds only the outer open parenthesis, the error skip
// flag is clear and both channels are empty. After an error, characters are
// dropped up to and including the end character, which still gives the end
// marker.
module infix_to_postfix_converter
  import ipc_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  stk_req_t   stk_req;
  logic [7:0] stk_rdata;
  emit_req_t  emit_req;
  logic       emit_ready;

  ipc_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_data_i    (in_data_i),
    .stk_o        (stk_req),
    .stk_rdata_i  (stk_rdata),
    .emit_o       (emit_req),
    .emit_ready_i (emit_ready)
  );

  ipc_stack u_stack (
    .clk_i     (clk_i),
    .req_i     (stk_req),
    .rd_data_o (stk_rdata)
  );

  ipc_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (emit_req),
    .ready_o     (emit_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
